>>> rtl/ggps_pkg.sv
// Shared types and codes for the gripper grab/place sequencer.
package ggps_pkg;

   localparam int unsigned CFG_W   = 16;
   localparam int unsigned LEVEL_W = 17;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 32;

   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_GRAB  = 2'd1,
      REQ_PLACE = 2'd2,
      REQ_ABORT = 2'd3
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TIMEOUT    = 2'd0,
      CSR_GRIP_START = 2'd1,
      CSR_GRIP_STEP  = 2'd2,
      CSR_GRIP_LIMIT = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_EXTEND  = 3'd1,
      PH_WORK    = 3'd2,
      PH_MID     = 3'd3,
      PH_RETRACT = 3'd4,
      PH_DONE    = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      ARM_NONE    = 2'd0,
      ARM_EXTEND  = 2'd1,
      ARM_RETRACT = 2'd2
   } arm_cmd_type;

   localparam logic signed [1:0] SENSE_POS = 2'sb01;
   localparam logic signed [1:0] SENSE_NEG = 2'sb11;

   localparam logic [CFG_W-1:0] TIMEOUT_RST    = 16'd100;
   localparam logic [CFG_W-1:0] GRIP_START_RST = 16'd16384;
   localparam logic [CFG_W-1:0] GRIP_STEP_RST  = 16'd1024;
   localparam logic [CFG_W-1:0] GRIP_LIMIT_RST = 16'd65535;

   typedef struct packed {
      logic [CFG_W-1:0] timeout_ticks;
      logic [CFG_W-1:0] grip_start;
      logic [CFG_W-1:0] grip_step;
      logic [CFG_W-1:0] grip_limit;
   } cfg_type;

   typedef struct packed {
      phase_type          grab;
      phase_type          place;
      logic [LEVEL_W-1:0] grip_level;
      logic [CFG_W-1:0]   elapsed;
      logic               busy;
   } seq_state_type;

   typedef struct packed {
      req_kind_type      kind;
      logic signed [1:0] arm_position;
      logic signed [1:0] gripper_position;
      logic              hatch_held;
   } req_word_type;

   // lowest field last so the packed vector matches the bus layout
   typedef struct packed {
      logic [2:0]       place_phase;
      logic [2:0]       grab_phase;
      logic             fault;
      logic             busy_res;
      logic             grip_write;
      logic [CFG_W-1:0] grip_drive;
      logic [1:0]       arm_drive;
   } rsp_word_type;

   localparam int unsigned RSP_FIELDS_W = $bits(rsp_word_type);

endpackage

>>> rtl/ggps_step.sv
// Next-state and result logic for one word of the sequencer.
module ggps_step (
   input  ggps_pkg::cfg_type       cfg,
   input  ggps_pkg::seq_state_type cur,
   input  ggps_pkg::req_word_type  req,
   output ggps_pkg::seq_state_type nxt,
   output ggps_pkg::rsp_word_type  rsp
);
   import ggps_pkg::*;

   logic               timed_out;
   logic               grab_fin;
   logic               place_fin;
   logic               moved;
   logic               fault;
   arm_cmd_type        arm_cmd;
   logic [CFG_W-1:0]   grip;
   logic               gwrite;
   logic [LEVEL_W-1:0] ramp_sum;

   assign timed_out = cur.elapsed > cfg.timeout_ticks;
   assign ramp_sum  = cur.grip_level + {1'b0, cfg.grip_step};

   always_comb begin
      nxt       = cur;
      moved     = 1'b0;
      fault     = 1'b0;
      arm_cmd   = ARM_NONE;
      grip      = '0;
      gwrite    = 1'b0;
      grab_fin  = 1'b0;
      place_fin = 1'b0;

      case (req.kind)
         REQ_TICK: begin
            case (cur.grab)
               PH_IDLE: grab_fin = 1'b1;
               PH_EXTEND: begin
                  arm_cmd = ARM_EXTEND;
                  if (req.arm_position == SENSE_POS || timed_out) begin
                     nxt.grab       = PH_WORK;
                     nxt.grip_level = {1'b0, cfg.grip_start};
                     moved          = 1'b1;
                  end
               end
               PH_WORK: begin
                  grip           = cur.grip_level[LEVEL_W-1] ? '1
                                                             : cur.grip_level[CFG_W-1:0];
                  gwrite         = 1'b1;
                  nxt.grip_level = ramp_sum;
                  if (req.hatch_held || ramp_sum >= {1'b0, cfg.grip_limit}) begin
                     nxt.grab = PH_MID;
                     moved    = 1'b1;
                  end
               end
               PH_MID: begin
                  nxt.grab = PH_RETRACT;
                  moved    = 1'b1;
               end
               PH_RETRACT: begin
                  arm_cmd = ARM_RETRACT;
                  if (req.arm_position == SENSE_NEG || timed_out) begin
                     nxt.grab = PH_DONE;
                     moved    = 1'b1;
                  end
               end
               PH_DONE: begin
                  nxt.grab = PH_IDLE;
                  moved    = 1'b1;
                  grab_fin = 1'b1;
               end
               default: begin
                  nxt.grab = PH_IDLE;
                  moved    = 1'b1;
                  fault    = 1'b1;
                  grab_fin = 1'b1;
               end
            endcase

            // place only steps once grab is out of the way
            if (grab_fin) begin
               case (cur.place)
                  PH_IDLE: place_fin = 1'b1;
                  PH_EXTEND: begin
                     arm_cmd = ARM_EXTEND;
                     if (req.arm_position == SENSE_POS || timed_out) begin
                        nxt.place = PH_WORK;
                        moved     = 1'b1;
                     end
                  end
                  PH_WORK: begin
                     grip   = '0;
                     gwrite = 1'b1;
                     if (req.gripper_position == SENSE_NEG || timed_out) begin
                        nxt.place = PH_MID;
                        moved     = 1'b1;
                     end
                  end
                  PH_MID: begin
                     nxt.place = PH_RETRACT;
                     moved     = 1'b1;
                  end
                  PH_RETRACT: begin
                     arm_cmd = ARM_RETRACT;
                     if (req.arm_position == SENSE_NEG || timed_out) begin
                        nxt.place = PH_DONE;
                        moved     = 1'b1;
                     end
                  end
                  PH_DONE: begin
                     nxt.place = PH_IDLE;
                     moved     = 1'b1;
                     place_fin = 1'b1;
                  end
                  default: begin
                     nxt.place = PH_IDLE;
                     moved     = 1'b1;
                     fault     = 1'b1;
                     place_fin = 1'b1;
                  end
               endcase
            end

            nxt.busy = ~place_fin;
            if (moved) begin
               nxt.elapsed = '0;
            end else if (cur.elapsed != '1) begin
               nxt.elapsed = cur.elapsed + 1'b1;
            end
         end
         REQ_GRAB, REQ_PLACE: begin
            if (cur.grab == PH_IDLE && cur.place == PH_IDLE) begin
               if (req.kind == REQ_GRAB) begin
                  nxt.grab = PH_EXTEND;
               end else begin
                  nxt.place = PH_EXTEND;
               end
               nxt.elapsed = '0;
            end
         end
         default: begin
            nxt.grab  = PH_IDLE;
            nxt.place = PH_IDLE;
            nxt.busy  = 1'b0;
         end
      endcase

      rsp.arm_drive   = arm_cmd;
      rsp.grip_drive  = gwrite ? grip : '0;
      rsp.grip_write  = gwrite;
      rsp.busy_res    = nxt.busy;
      rsp.fault       = fault;
      rsp.grab_phase  = nxt.grab;
      rsp.place_phase = nxt.place;
   end

endmodule

>>> rtl/gripper_grab_place_sequencer_core.sv
// Top level of the gripper grab/place sequencer: state, config and result register.
//
//   channel  | direction | content
//   ---------+-----------+------------------------------------------------------
//   req_     | in        | tuser: word kind; tdata: arm, gripper, hatch readings
//   rsp_     | out       | tdata: drives, busy, fault, both phases
//   csr_     | in        | write enable, register index, 16-bit write data
//
// One word is accepted per cycle while ready; its result appears in the result register on the
// next cycle. The only loop is the sequence state register fed by one compare/add step.
// req_tready drops only while a result sits unclaimed and rsp_tready is low.
// Reset (synchronous) clears phases, counters, config and the valid flag to their defaults; result data is not reset.
module gripper_grab_place_sequencer_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ggps_pkg::REQ_DATA_W-1:0]     req_tdata,  // arm_position, gripper_position, hatch_held
   input  logic [1:0]                          req_tuser,  // req_type
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ggps_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // arm_drive, grip_drive, grip_write,
                                                           // busy_res, fault, grab_phase, place_phase
   input  logic                                csr_wr_en,
   input  logic [ggps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ggps_pkg::CFG_W-1:0]          csr_wdata
);
   import ggps_pkg::*;

   cfg_type       cfg_ff;
   seq_state_type state_ff;
   seq_state_type state_in;
   req_word_type  req_word;
   rsp_word_type  rsp_in;
   rsp_word_type  rsp_ff;
   logic          rsp_valid_ff;
   logic          accept;

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;

   assign req_word.kind             = req_kind_type'(req_tuser);
   assign req_word.arm_position     = req_tdata[1:0];
   assign req_word.gripper_position = req_tdata[3:2];
   assign req_word.hatch_held       = req_tdata[4];

   ggps_step u_step (
      .cfg (cfg_ff),
      .cur (state_ff),
      .req (req_word),
      .nxt (state_in),
      .rsp (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks <= TIMEOUT_RST;
         cfg_ff.grip_start    <= GRIP_START_RST;
         cfg_ff.grip_step     <= GRIP_STEP_RST;
         cfg_ff.grip_limit    <= GRIP_LIMIT_RST;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_TIMEOUT:    cfg_ff.timeout_ticks <= csr_wdata;
            CSR_GRIP_START: cfg_ff.grip_start    <= csr_wdata;
            CSR_GRIP_STEP:  cfg_ff.grip_step     <= csr_wdata;
            CSR_GRIP_LIMIT: cfg_ff.grip_limit    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.grab       <= PH_IDLE;
         state_ff.place      <= PH_IDLE;
         state_ff.grip_level <= '0;
         state_ff.elapsed    <= '0;
         state_ff.busy       <= 1'b0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   // hold the result until taken; load a new one on every accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-RSP_FIELDS_W){1'b0}}, rsp_ff};

endmodule
